// ===== src/edf_pkg.sv =====
// ----------------------------------------------------------------------------
// edf_pkg: shared types and constants of the EDF ready table scheduler
// Holds the command codes and the command record passed from front to back.
// ----------------------------------------------------------------------------
package edf_pkg;

    localparam logic [1:0] KIND_ARRIVE   = 2'd0;
    localparam logic [1:0] KIND_RETIRE   = 2'd1;
    localparam logic [1:0] KIND_SCHEDULE = 2'd2;

    localparam int ID_W       = 16;
    localparam int PRIO_W     = 8;
    localparam int DL_W       = 48;
    // Deadline bits kept in the table; no wider than the deadline field.
    localparam int TIME_BITS  = 48;
    localparam logic [PRIO_W-1:0] BASE_RESET   = 8'd104;
    localparam logic [PRIO_W-1:0] LOWEST_RESET = 8'd255;

    typedef struct packed {
        logic [1:0]      kind;
        logic [ID_W-1:0] task_id;
        logic [DL_W-1:0] deadline;
    } cmd_t;

    typedef struct packed {
        logic [ID_W-1:0]   task_id;
        logic [PRIO_W-1:0] prio;
        logic              entry_valid;
        logic              changed;
        logic              activate;
        logic              clamped;
        logic              dropped;
        logic              last;
    } res_t;

endpackage

// ===== src/edf_front.sv =====
// ----------------------------------------------------------------------------
// edf_front: command intake
// Drops meaningless commands and holds accepted ones in a short queue.
// ----------------------------------------------------------------------------
module edf_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    output logic          full,
    input  edf_pkg::cmd_t cmd,
    output logic          cmd_valid,
    output edf_pkg::cmd_t cmd_head,
    input  logic          cmd_take
);
    import edf_pkg::*;

    cmd_t       q_mem [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wr_reg, rd_reg;
    logic       keep;
    logic       wr_en, rd_en;

    // An arrive or retire with task id zero and the unused kind cause nothing, so they are not queued.
    assign keep = (cmd.kind == KIND_SCHEDULE) ||
                  ((cmd.kind == KIND_ARRIVE || cmd.kind == KIND_RETIRE) &&
                   cmd.task_id != '0);
    assign full      = (cnt_reg == 2'd2);
    assign wr_en     = push && !full && keep;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign rd_en     = cmd_take && cmd_valid;
    assign cmd_head  = q_mem[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg + 2'(wr_en) - 2'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (wr_en)
                wr_reg <= ~wr_reg;
            if (rd_en)
                rd_reg <= ~rd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            q_mem[wr_reg] <= cmd;
    end

endmodule

// ===== src/edf_back.sv =====
// ----------------------------------------------------------------------------
// edf_back: ready table and scheduling sequencer
// Executes one command at a time; a pass selects the next-earliest entry each
// step and emits its result into a one-entry output register.
// ----------------------------------------------------------------------------
module edf_back #(
    parameter int SLOTS     = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    input  edf_pkg::cmd_t             cmd_head,
    output logic                      cmd_take,
    input  logic [edf_pkg::PRIO_W-1:0] base_priority,
    input  logic [edf_pkg::PRIO_W-1:0] lowest_priority,
    output logic                      res_valid,
    output edf_pkg::res_t             res,
    input  logic                      res_take
);
    import edf_pkg::*;

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PASS = 2'd1;

    logic [ID_W-1:0]      task_reg   [SLOTS];
    logic [TIME_BITS-1:0] dl_reg     [SLOTS];
    logic [PRIO_W-1:0]    lastp_reg  [SLOTS];
    logic [SLOTS-1:0]     used_reg, started_reg, done_reg;
    logic                 drop_reg;
    logic [1:0]           state_reg;
    logic [CW-1:0]        rank_reg, left_reg;
    logic                 out_v_reg;
    res_t                 out_reg;

    logic [SLOTS-1:0] hit, freev, pend;
    logic [SW-1:0]    hit_idx, free_idx, best_idx;
    logic             any_hit, any_free, any_pend;
    logic [TIME_BITS-1:0] best_dl;
    logic [PRIO_W:0]  psum;
    logic [PRIO_W-1:0] prio;
    logic             clamp;
    logic             out_free;
    logic             out_load;
    logic [CW-1:0]    n_used;

    assign out_free  = !out_v_reg || res_take;
    assign res_valid = out_v_reg;
    assign res       = out_reg;

    always_comb
    begin
        hit = '0; freev = '0; pend = '0;
        hit_idx = '0; free_idx = '0; any_hit = 1'b0; any_free = 1'b0;
        n_used = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            hit[i]   = used_reg[i] && task_reg[i] == cmd_head.task_id;
            freev[i] = !used_reg[i];
            pend[i]  = used_reg[i] && !done_reg[i];
            n_used   = n_used + CW'(used_reg[i]);
        end
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                hit_idx = SW'(i); any_hit = 1'b1;
            end
            if (freev[i])
            begin
                free_idx = SW'(i); any_free = 1'b1;
            end
        end
        // Earliest pending deadline, lower slot wins ties.
        best_idx = '0; best_dl = '0; any_pend = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (pend[i] && (!any_pend || dl_reg[i] < best_dl))
            begin
                best_idx = SW'(i); best_dl = dl_reg[i]; any_pend = 1'b1;
            end
        end
        psum  = {1'b0, base_priority} + (PRIO_W+1)'(rank_reg) + 1'b1;
        clamp = psum >= {1'b0, lowest_priority};
        prio  = clamp ? lowest_priority : psum[PRIO_W-1:0];
    end

    assign cmd_take = (state_reg == ST_IDLE) && cmd_valid &&
                      (cmd_head.kind != KIND_SCHEDULE || out_free);

    // The output register is loaded by an empty-table pass or by a pass step.
    assign out_load = (cmd_take && cmd_head.kind == KIND_SCHEDULE && n_used == '0) ||
                      (state_reg == ST_PASS && out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            started_reg <= '0;
            done_reg    <= '0;
            drop_reg    <= 1'b0;
            state_reg   <= ST_IDLE;
            out_v_reg   <= 1'b0;
            rank_reg    <= '0;
            left_reg    <= '0;
            for (int i = 0; i < SLOTS; i++)
                task_reg[i] <= '0;
        end
        else
        begin
            if (out_load)
                out_v_reg <= 1'b1;
            else if (res_take)
                out_v_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_take)
                    begin
                        case (cmd_head.kind)
                            KIND_ARRIVE:
                            begin
                                if (any_hit)
                                    started_reg[hit_idx] <= 1'b0;
                                else if (any_free)
                                begin
                                    used_reg[free_idx]    <= 1'b1;
                                    started_reg[free_idx] <= 1'b0;
                                    task_reg[free_idx]    <= cmd_head.task_id;
                                end
                                else
                                    drop_reg <= 1'b1;
                            end
                            KIND_RETIRE:
                            begin
                                if (any_hit)
                                begin
                                    used_reg[hit_idx]    <= 1'b0;
                                    started_reg[hit_idx] <= 1'b0;
                                    task_reg[hit_idx]    <= '0;
                                end
                            end
                            default:
                            begin
                                if (n_used == '0)
                                begin
                                    out_reg <= '{default: '0, dropped: drop_reg,
                                                 last: 1'b1};
                                end
                                else
                                begin
                                    done_reg  <= '0;
                                    rank_reg  <= '0;
                                    left_reg  <= n_used;
                                    state_reg <= ST_PASS;
                                end
                            end
                        endcase
                    end
                end
                ST_PASS:
                begin
                    if (out_free)
                    begin
                        out_reg.entry_valid <= 1'b1;
                        out_reg.task_id     <= task_reg[best_idx];
                        out_reg.prio        <= prio;
                        out_reg.changed     <= prio != lastp_reg[best_idx];
                        out_reg.activate    <= !started_reg[best_idx];
                        out_reg.clamped     <= clamp;
                        out_reg.dropped     <= drop_reg;
                        out_reg.last        <= left_reg == CW'(1);
                        started_reg[best_idx] <= 1'b1;
                        done_reg[best_idx]    <= 1'b1;
                        rank_reg <= rank_reg + 1'b1;
                        left_reg <= left_reg - 1'b1;
                        if (left_reg == CW'(1))
                            state_reg <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // Payload storage: deadline and last priority need no reset.
    always_ff @(posedge clk)
    begin
        if (cmd_take && cmd_head.kind == KIND_ARRIVE)
        begin
            if (any_hit)
                dl_reg[hit_idx] <= cmd_head.deadline[TIME_BITS-1:0];
            else if (any_free)
            begin
                dl_reg[free_idx]    <= cmd_head.deadline[TIME_BITS-1:0];
                lastp_reg[free_idx] <= '0;
            end
        end
        if (state_reg == ST_PASS && out_free)
            lastp_reg[best_idx] <= prio;
    end

endmodule

// ===== src/edf_ready_table_scheduler.sv =====
// ----------------------------------------------------------------------------
// edf_ready_table_scheduler: earliest-deadline-first ready table
// Keeps a table of ready tasks and ranks them by deadline on request.
//
//   channel   handshake      payload
//   input     push / full    kind, task_id, deadline
//   result    empty / pop    entry_valid .. last (one item per ranked task)
//   config    cfg_we         cfg_index, cfg_data
//
// Arrive and retire items execute in the sequencer's idle state. A scheduling
// pass ranks one used slot per step, each step running a minimum search over
// the deadline comparators of all slots. A two-entry queue sits between intake
// and sequencer; a held result stalls only scheduling items and pass steps.
// Reset clears the table, flags and registers at once; no clearing pass runs.
// ----------------------------------------------------------------------------
module edf_ready_table_scheduler #(
    parameter int SLOTS     = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  kind,
    input  logic [15:0] task_id,
    input  logic [47:0] deadline,
    output logic        empty,
    input  logic        pop,
    output logic        entry_valid,
    output logic [15:0] out_task_id,
    output logic [7:0]  priority_res,
    output logic        priority_changed,
    output logic        activate,
    output logic        clamped,
    output logic        arrival_dropped,
    output logic        last,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import edf_pkg::*;

    localparam logic CFG_BASE   = 1'b0;
    localparam logic CFG_LOWEST = 1'b1;

    cmd_t              cmd, cmd_head;
    res_t              res;
    logic              cmd_valid, cmd_take, res_valid;
    logic [PRIO_W-1:0] base_reg, lowest_reg;

    // The index port is one bit wide, so every write lands on a real register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= BASE_RESET;
            lowest_reg <= LOWEST_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BASE:   base_reg   <= cfg_data;
                CFG_LOWEST: lowest_reg <= cfg_data;
                default:    base_reg   <= base_reg;
            endcase
        end
    end

    assign cmd.kind     = kind;
    assign cmd.task_id  = task_id;
    assign cmd.deadline = deadline;

    edf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_head  (cmd_head),
        .cmd_take  (cmd_take)
    );

    edf_back #(
        .SLOTS     (SLOTS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_head        (cmd_head),
        .cmd_take        (cmd_take),
        .base_priority   (base_reg),
        .lowest_priority (lowest_reg),
        .res_valid       (res_valid),
        .res             (res),
        .res_take        (pop)
    );

    assign empty            = !res_valid;
    assign entry_valid      = res.entry_valid;
    assign out_task_id      = res.task_id;
    assign priority_res     = res.prio;
    assign priority_changed = res.changed;
    assign activate         = res.activate;
    assign clamped          = res.clamped;
    assign arrival_dropped  = res.dropped;
    assign last             = res.last;

endmodule

// ===== tb/tb_edf_ready_table_scheduler.sv =====
// ----------------------------------------------------------------------------
// tb_edf_ready_table_scheduler: self-checking bench for the EDF ready table
// Feeds arrive, retire and scheduling items through the input queue port, keeps
// a behavioral copy of the ready table to predict every ranked result, and
// compares each popped result field by field under several register settings.
// ----------------------------------------------------------------------------
module tb_edf_ready_table_scheduler;

    import edf_pkg::*;

    localparam int NSLOT    = 8;
    localparam int SETTLE   = 20;
    localparam int MAX_SHOW = 10;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [1:0]  kind;
    logic [15:0] task_id;
    logic [47:0] deadline;
    logic        empty;
    logic        pop = 1'b0;
    logic        entry_valid;
    logic [15:0] out_task_id;
    logic [7:0]  priority_res;
    logic        priority_changed;
    logic        activate;
    logic        clamped;
    logic        arrival_dropped;
    logic        last;
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [7:0]  cfg_data = 8'd0;

    // The item currently offered on the input ports.
    cmd_t drive_cmd = '0;

    assign kind     = drive_cmd.kind;
    assign task_id  = drive_cmd.task_id;
    assign deadline = drive_cmd.deadline;

    edf_ready_table_scheduler u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .kind             (kind),
        .task_id          (task_id),
        .deadline         (deadline),
        .empty            (empty),
        .pop              (pop),
        .entry_valid      (entry_valid),
        .out_task_id      (out_task_id),
        .priority_res     (priority_res),
        .priority_changed (priority_changed),
        .activate         (activate),
        .clamped          (clamped),
        .arrival_dropped  (arrival_dropped),
        .last             (last),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------------
    // Shadow copy of the ready table. It is updated when an item is accepted,
    // so predictions follow the exact order in which the block sees items.
    // ------------------------------------------------------------------------
    logic [PRIO_W-1:0] base_prio   = BASE_RESET;
    logic [PRIO_W-1:0] lowest_prio = LOWEST_RESET;
    logic [ID_W-1:0]   tbl_task [NSLOT];
    logic [DL_W-1:0]   tbl_dl   [NSLOT];
    bit                tbl_used [NSLOT];
    bit                tbl_started [NSLOT];
    logic [PRIO_W-1:0] tbl_prio [NSLOT];
    bit                drop_flag = 1'b0;

    cmd_t pending_cmds [$];
    res_t ranked_results [$];

    int send_idle = 0;
    int recv_idle = 0;
    int n_items = 0;
    int n_passes = 0;
    int n_results = 0;
    int n_errors = 0;

    initial begin
        for (int i = 0; i < NSLOT; i++) begin
            tbl_task[i]    = '0;
            tbl_dl[i]      = '0;
            tbl_used[i]    = 1'b0;
            tbl_started[i] = 1'b0;
            tbl_prio[i]    = '0;
        end
    end

    // An arrival refreshes the entry of its task if present, otherwise it takes
    // the lowest free slot. A full table drops it and sets the sticky flag.
    function automatic void table_arrive(logic [ID_W-1:0] id, logic [DL_W-1:0] dl);
        int free_slot;
        free_slot = -1;
        for (int i = 0; i < NSLOT; i++) begin
            if (tbl_used[i] && tbl_task[i] == id) begin
                tbl_dl[i]      = dl;
                tbl_started[i] = 1'b0;
                return;
            end
            if (!tbl_used[i] && free_slot < 0)
                free_slot = i;
        end
        if (free_slot < 0) begin
            drop_flag = 1'b1;
            return;
        end
        tbl_used[free_slot]    = 1'b1;
        tbl_task[free_slot]    = id;
        tbl_dl[free_slot]      = dl;
        tbl_started[free_slot] = 1'b0;
        tbl_prio[free_slot]    = '0;
    endfunction

    // A pass ranks used slots by deadline, lower slot first on a tie, and
    // queues one result per ranked task, or a single empty marker.
    function automatic void table_rank();
        int   order [NSLOT];
        int   cnt;
        int   v;
        int   j;
        int   p;
        res_t r;
        cnt = 0;
        for (int i = 0; i < NSLOT; i++)
            if (tbl_used[i]) begin
                order[cnt] = i;
                cnt++;
            end
        for (int i = 1; i < cnt; i++) begin
            v = order[i];
            j = i - 1;
            while (j >= 0 && (tbl_dl[v] < tbl_dl[order[j]] ||
                              (tbl_dl[v] == tbl_dl[order[j]] && v < order[j]))) begin
                order[j + 1] = order[j];
                j--;
            end
            order[j + 1] = v;
        end
        n_passes++;
        if (cnt == 0) begin
            r         = '0;
            r.dropped = drop_flag;
            r.last    = 1'b1;
            ranked_results.push_back(r);
            return;
        end
        for (int k = 0; k < cnt; k++) begin
            v = order[k];
            p = int'(base_prio) + k + 1;
            r = '0;
            if (p >= int'(lowest_prio)) begin
                p         = int'(lowest_prio);
                r.clamped = 1'b1;
            end
            r.entry_valid = 1'b1;
            r.task_id     = tbl_task[v];
            r.prio        = p[PRIO_W-1:0];
            r.changed     = (p[PRIO_W-1:0] != tbl_prio[v]);
            r.activate    = !tbl_started[v];
            r.dropped     = drop_flag;
            r.last        = (k == cnt - 1);
            tbl_prio[v]    = p[PRIO_W-1:0];
            tbl_started[v] = 1'b1;
            ranked_results.push_back(r);
        end
    endfunction

    function automatic void apply_item(cmd_t c);
        case (c.kind)
            KIND_ARRIVE:
                if (c.task_id != '0)
                    table_arrive(c.task_id, c.deadline);
            KIND_RETIRE:
                if (c.task_id != '0)
                    for (int i = 0; i < NSLOT; i++)
                        if (tbl_used[i] && tbl_task[i] == c.task_id) begin
                            tbl_used[i]    = 1'b0;
                            tbl_task[i]    = '0;
                            tbl_started[i] = 1'b0;
                        end
            KIND_SCHEDULE:
                table_rank();
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Driver: offers the next pending item, holds it while full is high, and
    // idles at random between items according to send_idle.
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            push <= 1'b0;
        end
        else begin
            if (push && !full) begin
                apply_item(drive_cmd);
                n_items++;
            end
            if (!push || !full) begin
                if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle) begin
                    drive_cmd <= pending_cmds.pop_front();
                    push      <= 1'b1;
                end
                else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: samples the result ports on the edge where an item is popped and
    // checks it against the oldest predicted result.
    // ------------------------------------------------------------------------
    function automatic void note_error(string what, logic [63:0] exp_v, logic [63:0] act_v);
        n_errors++;
        if (n_errors <= MAX_SHOW)
            $display("MISMATCH result %0d %s: expected 0x%0h, got 0x%0h",
                     n_results, what, exp_v, act_v);
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pop <= 1'b0;
        end
        else begin
            if (pop && !empty) begin
                if (ranked_results.size() == 0) begin
                    n_errors++;
                    if (n_errors <= MAX_SHOW)
                        $display("MISMATCH unexpected result for task 0x%0h", out_task_id);
                end
                else begin
                    res_t e;
                    e = ranked_results.pop_front();
                    if (entry_valid !== e.entry_valid)
                        note_error("entry_valid", e.entry_valid, entry_valid);
                    if (out_task_id !== e.task_id)
                        note_error("out_task_id", e.task_id, out_task_id);
                    if (priority_res !== e.prio)
                        note_error("priority_res", e.prio, priority_res);
                    if (priority_changed !== e.changed)
                        note_error("priority_changed", e.changed, priority_changed);
                    if (activate !== e.activate)
                        note_error("activate", e.activate, activate);
                    if (clamped !== e.clamped)
                        note_error("clamped", e.clamped, clamped);
                    if (arrival_dropped !== e.dropped)
                        note_error("arrival_dropped", e.dropped, arrival_dropped);
                    if (last !== e.last)
                        note_error("last", e.last, last);
                end
                n_results++;
            end
            pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    function automatic void queue_item(logic [1:0] k, logic [ID_W-1:0] id,
                                       logic [DL_W-1:0] dl);
        cmd_t c;
        c.kind     = k;
        c.task_id  = id;
        c.deadline = dl;
        pending_cmds.push_back(c);
    endfunction

    // Most ids come from a small pool so that updates, retires and a full
    // table happen often; a few are wide random ids or the null id.
    function automatic logic [ID_W-1:0] pick_id();
        int sel;
        sel = $urandom_range(99);
        if (sel < 85)
            return ID_W'($urandom_range(12, 1));
        else if (sel < 93)
            return ID_W'($urandom);
        return '0;
    endfunction

    // Small deadlines and deadlines near the top give many ties; the others are fully random or up to 1000.
    function automatic logic [DL_W-1:0] pick_deadline();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(3))
            0: return DL_W'($urandom_range(3));
            1: return w[DL_W-1:0];
            2: return {DL_W{1'b1}} - DL_W'($urandom_range(3));
            default: return DL_W'($urandom_range(1000));
        endcase
    endfunction

    // Random traffic draws each item independently: mostly arrivals, then scheduling
    // passes and retires, with a little noise of the unused kind mixed in.
    task automatic queue_random(int count);
        int sel;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(99);
            if (sel < 45)
                queue_item(KIND_ARRIVE, pick_id(), pick_deadline());
            else if (sel < 65)
                queue_item(KIND_RETIRE, pick_id(), DL_W'({$urandom, $urandom}));
            else if (sel < 95)
                queue_item(KIND_SCHEDULE, ID_W'($urandom), DL_W'({$urandom, $urandom}));
            else
                queue_item(2'd3, pick_id(), pick_deadline());
        end
    endtask

    // Registers are written only while the block holds nothing in flight.
    task automatic write_reg(logic idx, logic [7:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == 1'b0)
            base_prio = val;
        else
            lowest_prio = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every pending item was accepted and every predicted result
    // was popped, then let arrivals and retires still in the block drain.
    task automatic wait_drained();
        @(negedge clk);
        while (pending_cmds.size() > 0 || push || ranked_results.size() > 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part at reset register values, sender 31% and receiver 80% idle.
        send_idle = 31;
        recv_idle = 80;
        queue_item(KIND_SCHEDULE, '0, '0);                     // empty table
        queue_item(KIND_ARRIVE, '0, 48'd5);                    // null id ignored
        queue_item(KIND_ARRIVE, 16'hFFFF, {DL_W{1'b1}});
        queue_item(KIND_ARRIVE, 16'h0001, '0);
        queue_item(KIND_ARRIVE, 16'h0002, 48'd7);
        queue_item(KIND_ARRIVE, 16'h0003, 48'd7);              // tie with slot below
        queue_item(KIND_SCHEDULE, '1, '1);
        queue_item(KIND_ARRIVE, 16'h0002, 48'd1);              // update, clears mark
        queue_item(KIND_RETIRE, 16'h1234, '0);                 // unknown task
        queue_item(KIND_RETIRE, '0, '0);                       // null id ignored
        queue_item(2'd3, 16'h0003, 48'd0);                     // unused kind
        queue_item(KIND_SCHEDULE, '0, '0);
        for (int i = 4; i <= 9; i++)                           // fills, then overflows
            queue_item(KIND_ARRIVE, ID_W'(16'h5550 + i), 48'hAAAA_5555_0000 + i);
        queue_item(KIND_SCHEDULE, '0, '0);
        queue_item(KIND_RETIRE, 16'hFFFF, '0);
        queue_item(KIND_RETIRE, 16'h0001, '0);
        queue_item(KIND_SCHEDULE, '0, '0);
        wait_drained();

        // The sender stops here until the table has emptied its results.
        write_reg(1'b0, 8'd250);
        write_reg(1'b1, 8'd252);
        queue_random(125);
        wait_drained();

        // Base above lowest: every priority clamps. Idling reversed.
        send_idle = 80;
        recv_idle = 31;
        write_reg(1'b0, 8'd255);
        write_reg(1'b1, 8'd0);
        queue_random(60);
        wait_drained();
        write_reg(1'b0, 8'd0);
        write_reg(1'b1, 8'd255);
        queue_random(65);
        wait_drained();

        // Full rate on both sides with a middle setting.
        send_idle = 0;
        recv_idle = 0;
        write_reg(1'b0, 8'd100);
        write_reg(1'b1, 8'd103);
        queue_random(120);
        wait_drained();

        if (ranked_results.size() != 0)
            n_errors++;
        $display("Covered %0d items, %0d scheduling passes, %0d results checked.",
                 n_items, n_passes, n_results);
        $display("Register settings ran from no clamping to full clamping; %0d mismatches.",
                 n_errors);
        if (n_errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #5000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
